// ===== rtl/ssaie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssaie_pkg;

   // storage sizes
   localparam int SLOTS     = 1024;
   localparam int SLOT_AW   = 10;
   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW    = 16;
   localparam int REG_COUNT = 32;
   localparam int REG_AW    = 5;
   localparam int VAL_W     = 64;
   localparam int WID_W     = 7;

   localparam logic [WID_W-1:0] FULL_WIDTH = 7'd64;

   // opcodes
   localparam logic [4:0] OP_NOT      = 5'd0;
   localparam logic [4:0] OP_ADD      = 5'd1;
   localparam logic [4:0] OP_SUB      = 5'd2;
   localparam logic [4:0] OP_AND      = 5'd3;
   localparam logic [4:0] OP_OR       = 5'd4;
   localparam logic [4:0] OP_XOR      = 5'd5;
   localparam logic [4:0] OP_SHL      = 5'd6;
   localparam logic [4:0] OP_SHR      = 5'd7;
   localparam logic [4:0] OP_CAT      = 5'd8;
   localparam logic [4:0] OP_EXTRACT  = 5'd9;
   localparam logic [4:0] OP_EQ       = 5'd10;
   localparam logic [4:0] OP_NEQ      = 5'd11;
   localparam logic [4:0] OP_TERNARY  = 5'd12;
   localparam logic [4:0] OP_ASSERT   = 5'd13;
   localparam logic [4:0] OP_CONST    = 5'd14;
   localparam logic [4:0] OP_MEMSPACE = 5'd15;
   localparam logic [4:0] OP_LOAD8    = 5'd16;
   localparam logic [4:0] OP_LOAD16   = 5'd17;
   localparam logic [4:0] OP_LOAD32   = 5'd18;
   localparam logic [4:0] OP_LOAD64   = 5'd19;
   localparam logic [4:0] OP_STORE8   = 5'd20;
   localparam logic [4:0] OP_STORE16  = 5'd21;
   localparam logic [4:0] OP_STORE32  = 5'd22;

   // memory space selectors
   localparam logic [VAL_W-1:0] SPACE_REG  = 64'd0;
   localparam logic [VAL_W-1:0] SPACE_BYTE = 64'd1;

   // slot read address select
   localparam logic [1:0] RD_A = 2'd0;
   localparam logic [1:0] RD_B = 2'd1;
   localparam logic [1:0] RD_C = 2'd2;
   localparam logic [1:0] RD_D = 2'd3;

   typedef struct packed {
      logic [1:0] rd_sel;
      logic       latch;
      logic       cap_a;
      logic       cap_b;
      logic       cap_c;
      logic       cap_d;
      logic       mem_issue;
      logic       mem_cap;
      logic       wb;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic byte_access;
      logic is_store;
      logic byte_last;
      logic out_busy;
   } status_type;

   // mask of the low w bits, full at 64 and above
   function automatic logic [VAL_W-1:0] width_mask(input logic [7:0] w);
      logic [VAL_W-1:0] m;
      if (w >= 8'd64) begin
         m = {VAL_W{1'b1}};
      end else begin
         m = (64'd1 << w[5:0]) - 64'd1;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ssaie_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ssaie_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  req_type;
   logic [9:0]  dest_slot;
   logic [9:0]  arg_a;
   logic [9:0]  arg_b;
   logic [9:0]  arg_c;
   logic [31:0] const_value;
   logic [6:0]  const_bits;
   logic        is_store64;

   modport source (output valid, req_type, dest_slot, arg_a, arg_b, arg_c,
                   const_value, const_bits, is_store64, input ready);
   modport sink (input valid, req_type, dest_slot, arg_a, arg_b, arg_c,
                 const_value, const_bits, is_store64, output ready);
endinterface

interface ssaie_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  slot;
   logic [63:0] value;
   logic [6:0]  width;

   modport source (output valid, slot, value, width, input ready);
   modport sink (input valid, slot, value, width, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssa_ir_executor_top.sv =====
// Flow: an accepted word is latched, then four sequential reads on the single slot read
//   port fetch the three arguments and the destination slot; byte-memory accesses then
//   step through the one-byte-wide byte memory port, and the result is written back.
//   One instruction runs at a time; no new word is accepted before write-back.
// Reset: synchronous; afterwards a clearing pass zeroes the slot store and byte memory,
//   with no word accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none

module ssa_ir_executor_top (
   input  wire logic clock,
   input  wire logic reset,
   ssaie_req_if.sink   req_chan,
   ssaie_rsp_if.source rsp_chan
);

   ssaie_pkg::cmd_type    cmd;
   ssaie_pkg::status_type status;

   // sequence the instruction
   ssaie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold stores and compute results
   ssaie_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_chan.req_type),
      .dest_slot   (req_chan.dest_slot),
      .arg_a       (req_chan.arg_a),
      .arg_b       (req_chan.arg_b),
      .arg_c       (req_chan.arg_c),
      .const_value (req_chan.const_value),
      .const_bits  (req_chan.const_bits),
      .is_store64  (req_chan.is_store64),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_slot    (rsp_chan.slot),
      .rsp_value   (rsp_chan.value),
      .rsp_width   (rsp_chan.width)
   );

   // no word taken while the clearing pass runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      !status.clear_done |-> !req_chan.ready)
      else $error("word accepted during clearing pass");

   // one instruction at a time
   a_single_issue: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second word accepted while busy");

   // recorded widths never exceed full width
   a_width_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.width <= 7'd64))
      else $error("result width above 64");

endmodule

`default_nettype wire

// ===== rtl/ssaie_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssaie_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ssaie_pkg::status_type status,
   output ssaie_pkg::cmd_type         cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RA    = 4'd2;
   localparam logic [3:0] S_RB    = 4'd3;
   localparam logic [3:0] S_RC    = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_CAP   = 4'd6;
   localparam logic [3:0] S_MRD   = 4'd7;
   localparam logic [3:0] S_MCAP  = 4'd8;
   localparam logic [3:0] S_WB    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // sequence one instruction through the slot and byte stores
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = ssaie_pkg::RD_A;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_RA;
            end
         end
         S_RA: begin
            cmd.rd_sel = ssaie_pkg::RD_A;
            state_in   = S_RB;
         end
         S_RB: begin
            cmd.rd_sel = ssaie_pkg::RD_B;
            cmd.cap_a  = 1'b1;
            state_in   = S_RC;
         end
         S_RC: begin
            cmd.rd_sel = ssaie_pkg::RD_C;
            cmd.cap_b  = 1'b1;
            state_in   = S_RD;
         end
         S_RD: begin
            cmd.rd_sel = ssaie_pkg::RD_D;
            cmd.cap_c  = 1'b1;
            state_in   = S_CAP;
         end
         S_CAP: begin
            cmd.cap_d = 1'b1;
            state_in  = status.byte_access ? S_MRD : S_WB;
         end
         S_MRD: begin
            cmd.mem_issue = 1'b1;
            if (!status.is_store) state_in = S_MCAP;
            else if (status.byte_last) state_in = S_WB;
         end
         S_MCAP: begin
            cmd.mem_cap = 1'b1;
            state_in    = status.byte_last ? S_WB : S_MRD;
         end
         S_WB: begin
            if (!status.out_busy) begin
               cmd.wb   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== rtl/ssaie_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssaie_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ssaie_pkg::cmd_type    cmd,
   output ssaie_pkg::status_type      status,
   input  wire logic [4:0]            req_type,
   input  wire logic [9:0]            dest_slot,
   input  wire logic [9:0]            arg_a,
   input  wire logic [9:0]            arg_b,
   input  wire logic [9:0]            arg_c,
   input  wire logic [31:0]           const_value,
   input  wire logic [6:0]            const_bits,
   input  wire logic                  is_store64,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [9:0]                 rsp_slot,
   output logic [63:0]                rsp_value,
   output logic [6:0]                 rsp_width
);

   localparam int SW = ssaie_pkg::VAL_W + ssaie_pkg::WID_W;

   // latched instruction
   logic [4:0]                      op_ff;
   logic [ssaie_pkg::SLOT_AW-1:0]   d_ff, ia_ff, ib_ff, ic_ff;
   logic [31:0]                     cval_ff;
   logic [6:0]                      cbits_ff;
   logic                            st64_ff;

   // operand values and widths
   logic [63:0] a_ff, b_ff, c_ff, dv_ff;
   logic [6:0]  wa_ff, wb_ff, wc_ff, wd_ff;

   // stores
   logic [SW-1:0]  slot_mem [ssaie_pkg::SLOTS];
   logic [SW-1:0]  slot_rd_ff;
   logic [7:0]     byte_mem [ssaie_pkg::MEM_BYTES];
   logic [7:0]     byte_rd_ff;
   logic [63:0]    reg_space_ff [ssaie_pkg::REG_COUNT];
   logic [ssaie_pkg::MEM_AW:0] clr_ff;
   logic           clear_done;

   logic [2:0]     k_ff;
   logic [63:0]    ld_ff;
   logic [ssaie_pkg::SLOT_AW-1:0] rd_addr;

   logic [1:0]     size;
   logic [3:0]     nbytes;
   logic [7:0]     nbits;
   logic           is_load, is_store;
   logic [ssaie_pkg::MEM_AW-1:0] byte_addr;
   logic [7:0]     st_byte;
   logic           reg_hit;
   logic [63:0]    reg_rd;
   logic [63:0]    nmask;

   logic [63:0]    v;
   logic [7:0]     w;
   logic           do_write;
   logic [63:0]    v_final;

   logic           rsp_valid_ff;
   logic [9:0]     rsp_slot_ff;
   logic [63:0]    rsp_value_ff;
   logic [6:0]     rsp_width_ff;

   assign clear_done = clr_ff[ssaie_pkg::MEM_AW];

   // decode access size
   assign is_load  = (op_ff >= ssaie_pkg::OP_LOAD8) && (op_ff <= ssaie_pkg::OP_LOAD64);
   assign is_store = (op_ff >= ssaie_pkg::OP_STORE8) && (op_ff <= ssaie_pkg::OP_STORE32);
   always_comb begin
      if (is_load) size = op_ff[1:0];
      else if (op_ff == ssaie_pkg::OP_STORE32) size = st64_ff ? 2'd3 : 2'd2;
      else size = op_ff[1:0] - 2'd0;
   end
   assign nbytes = 4'd1 << size;
   assign nbits  = {1'b0, nbytes, 3'b000};
   assign nmask  = ssaie_pkg::width_mask(nbits);

   assign byte_addr = b_ff[ssaie_pkg::MEM_AW-1:0] + ssaie_pkg::MEM_AW'(k_ff);
   assign st_byte   = 8'(c_ff >> {k_ff, 3'b000});
   assign reg_hit   = (b_ff < 64'(ssaie_pkg::REG_COUNT));
   assign reg_rd    = reg_hit ? reg_space_ff[b_ff[ssaie_pkg::REG_AW-1:0]] : 64'd0;

   assign status.clear_done  = clear_done;
   assign status.byte_access = (is_load || is_store) && (a_ff == ssaie_pkg::SPACE_BYTE);
   assign status.is_store    = is_store;
   assign status.byte_last   = ({1'b0, k_ff} == nbytes - 4'd1);
   assign status.out_busy    = rsp_valid_ff && !rsp_ready;

   // pick the slot read address
   always_comb begin
      unique case (cmd.rd_sel)
         ssaie_pkg::RD_A: rd_addr = ia_ff;
         ssaie_pkg::RD_B: rd_addr = ib_ff;
         ssaie_pkg::RD_C: rd_addr = ic_ff;
         default:         rd_addr = d_ff;
      endcase
   end

   // latch the instruction word and capture operands
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_type;
         d_ff     <= dest_slot[ssaie_pkg::SLOT_AW-1:0];
         ia_ff    <= arg_a[ssaie_pkg::SLOT_AW-1:0];
         ib_ff    <= arg_b[ssaie_pkg::SLOT_AW-1:0];
         ic_ff    <= arg_c[ssaie_pkg::SLOT_AW-1:0];
         cval_ff  <= const_value;
         cbits_ff <= const_bits;
         st64_ff  <= is_store64;
      end
      if (cmd.cap_a) {a_ff, wa_ff} <= slot_rd_ff;
      if (cmd.cap_b) {b_ff, wb_ff} <= slot_rd_ff;
      if (cmd.cap_c) {c_ff, wc_ff} <= slot_rd_ff;
      if (cmd.cap_d) {dv_ff, wd_ff} <= slot_rd_ff;
   end

   // step through the bytes of a byte-memory access
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         k_ff  <= 3'd0;
         ld_ff <= 64'd0;
      end else begin
         if (cmd.mem_cap) ld_ff <= ld_ff | (64'(byte_rd_ff) << {k_ff, 3'b000});
         if (cmd.mem_cap || (cmd.mem_issue && is_store)) k_ff <= k_ff + 3'd1;
      end
   end

   // sweep the clear pointer after reset
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (!clear_done) clr_ff <= clr_ff + 1'b1;
   end

   // slot store
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         if (clr_ff[ssaie_pkg::MEM_AW-1:0] < ssaie_pkg::MEM_AW'(ssaie_pkg::SLOTS))
            slot_mem[clr_ff[ssaie_pkg::SLOT_AW-1:0]] <= '0;
      end else if (cmd.wb && do_write) begin
         slot_mem[d_ff] <= {v_final, w[6:0]};
      end
      slot_rd_ff <= slot_mem[rd_addr];
   end

   // byte memory
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         byte_mem[clr_ff[ssaie_pkg::MEM_AW-1:0]] <= 8'd0;
      end else if (cmd.mem_issue && is_store) begin
         byte_mem[byte_addr] <= st_byte;
      end
      byte_rd_ff <= byte_mem[byte_addr];
   end

   // register space
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssaie_pkg::REG_COUNT; i++) reg_space_ff[i] <= 64'd0;
      end else if (cmd.wb && is_store && (a_ff == ssaie_pkg::SPACE_REG) && reg_hit) begin
         reg_space_ff[b_ff[ssaie_pkg::REG_AW-1:0]] <=
            (reg_rd & ~nmask) | (c_ff & nmask);
      end
   end

   // compute the destination value and width
   always_comb begin
      v        = 64'd0;
      w        = 8'd0;
      do_write = 1'b1;
      case (op_ff)
         ssaie_pkg::OP_NOT: begin v = ~a_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_ADD: begin v = a_ff + b_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_SUB: begin
            v = a_ff - b_ff;
            w = (wa_ff >= ssaie_pkg::FULL_WIDTH) ? 8'd64 : {1'b0, wa_ff} + 8'd1;
         end
         ssaie_pkg::OP_AND: begin v = a_ff & b_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_OR:  begin v = a_ff | b_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_XOR: begin v = a_ff ^ b_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_SHL: begin
            if (b_ff >= 64'd64) begin
               v = 64'd0; w = 8'd64;
            end else begin
               v = a_ff << b_ff[5:0];
               w = ({1'b0, wa_ff} + {2'b00, b_ff[5:0]} > 8'd64) ? 8'd64 :
                   {1'b0, wa_ff} + {2'b00, b_ff[5:0]};
            end
         end
         ssaie_pkg::OP_SHR: begin
            v = (b_ff >= 64'd64) ? 64'd0 : a_ff >> b_ff[5:0];
            w = (b_ff >= 64'(wa_ff)) ? 8'd0 : {1'b0, wa_ff - b_ff[6:0]};
         end
         ssaie_pkg::OP_CAT: begin
            v = b_ff | ((wb_ff >= ssaie_pkg::FULL_WIDTH) ? 64'd0 : a_ff << wb_ff[5:0]);
            w = ({1'b0, wa_ff} + {1'b0, wb_ff} > 8'd64) ? 8'd64 :
                {1'b0, wa_ff} + {1'b0, wb_ff};
         end
         ssaie_pkg::OP_EXTRACT: begin
            v = (b_ff >= 64'd64) ? 64'd0 : a_ff >> b_ff[5:0];
            w = (c_ff >= 64'd64) ? 8'd64 : {1'b0, c_ff[6:0]};
         end
         ssaie_pkg::OP_EQ:  begin v = {63'd0, a_ff == b_ff}; w = 8'd1; end
         ssaie_pkg::OP_NEQ: begin v = {63'd0, a_ff != b_ff}; w = 8'd1; end
         ssaie_pkg::OP_TERNARY: begin
            if (a_ff != 64'd0) begin v = b_ff; w = {1'b0, wb_ff}; end
            else begin v = c_ff; w = {1'b0, wc_ff}; end
         end
         ssaie_pkg::OP_CONST: begin
            v = {32'd0, cval_ff};
            w = (cbits_ff > ssaie_pkg::FULL_WIDTH) ? 8'd64 : {1'b0, cbits_ff};
         end
         ssaie_pkg::OP_MEMSPACE: begin v = a_ff; w = {1'b0, wa_ff}; end
         ssaie_pkg::OP_LOAD8, ssaie_pkg::OP_LOAD16,
         ssaie_pkg::OP_LOAD32, ssaie_pkg::OP_LOAD64: begin
            if (a_ff == ssaie_pkg::SPACE_REG) v = reg_rd & nmask;
            else if (a_ff == ssaie_pkg::SPACE_BYTE) v = ld_ff;
            else v = 64'd0;
            w = nbits;
         end
         ssaie_pkg::OP_STORE8, ssaie_pkg::OP_STORE16, ssaie_pkg::OP_STORE32: begin
            v = c_ff; w = nbits;
         end
         default: begin
            do_write = 1'b0;
            v        = dv_ff;
            w        = {1'b0, wd_ff};
         end
      endcase
   end

   assign v_final = v & ssaie_pkg::width_mask(w);

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.wb) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.wb) begin
         rsp_slot_ff  <= 10'(d_ff);
         rsp_value_ff <= do_write ? v_final : dv_ff;
         rsp_width_ff <= w[6:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_width = rsp_width_ff;

endmodule

`default_nettype wire
